// ===== design/prg_pkg.sv =====
package prg_pkg;

    // Fraction bits of the basis and eye components
    localparam int VEC_FRAC_BITS = 12;

    // Sample-to-window mapping
    localparam int RATIO_BITS   = 24;
    localparam int RATIO_STEPS  = 5;
    localparam int RATIO_STAGES = 5;

    // Direction normalization
    localparam int DW           = 54;
    localparam int NORM_BITS    = 30;
    localparam int DIR_FRAC     = 14;
    localparam int SQRT_STEPS   = 4;
    localparam int SQRT_STAGES  = 8;
    localparam int DIV_STEPS    = 5;
    localparam int DIV_STAGES   = 3;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_U      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_V      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_W      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EYE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_V     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER       = 3'd7;

    // 640 x 480
    localparam logic [31:0] RASTER_RESET = 32'd41943520;

endpackage

// ===== design/prg_ratio.sv =====
// Maps a raster position plus sub-pixel offset to a clamped Q.24 ratio.
// Two pipelined restoring dividers, one quotient bit per step.
module prg_ratio (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] pixel_x,
    input  logic [15:0] pixel_y,
    input  logic [15:0] offset_x,
    input  logic [15:0] offset_y,
    input  logic [31:0] raster_size,
    output logic        out_valid,
    output logic [24:0] ratio_x,
    output logic [24:0] ratio_y
);

    localparam int NS = prg_pkg::RATIO_STAGES;
    localparam logic [24:0] ONE = 25'(1) << prg_pkg::RATIO_BITS;

    typedef struct packed {
        logic [15:0] rem;
        logic [24:0] num;
        logic        clamp;
    } lane_t;

    function automatic lane_t lane_init(input logic [15:0] pix, input logic [15:0] off,
                                        input logic [15:0] size);
        logic [39:0] s;
        lane_t       l;
        s       = {pix, off, 8'b0};
        l.clamp = ({1'b0, s[39:25]} >= size);
        l.rem   = {1'b0, s[39:25]};
        l.num   = s[24:0];
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t li, input logic [15:0] size);
        logic [16:0] t;
        lane_t       l;
        l = li;
        t = {l.rem, l.num[24]};
        if (t >= {1'b0, size})
        begin
            t     = t - {1'b0, size};
            l.rem = t[15:0];
            l.num = {l.num[23:0], 1'b1};
        end
        else
        begin
            l.rem = t[15:0];
            l.num = {l.num[23:0], 1'b0};
        end
        return l;
    endfunction

    function automatic logic [24:0] lane_final(input lane_t l);
        return (l.clamp || (l.num > ONE)) ? ONE : l.num;
    endfunction

    logic [15:0] size_x;
    logic [15:0] size_y;
    lane_t       lx_reg [NS+1];
    lane_t       ly_reg [NS+1];
    lane_t       lx_next [NS+1];
    lane_t       ly_next [NS+1];
    logic [NS+1:0] vld_reg;
    logic [24:0] rx_reg;
    logic [24:0] ry_reg;
    logic [24:0] rx_next;
    logic [24:0] ry_next;
    logic [24:0] ry_raw;

    // Zero dimension counts as one
    assign size_x = (raster_size[31:16] == 16'd0) ? 16'd1 : raster_size[31:16];
    assign size_y = (raster_size[15:0] == 16'd0) ? 16'd1 : raster_size[15:0];

    // Divider steps
    always_comb
    begin
        lane_t tx;
        lane_t ty;
        lx_next[0] = lane_init(pixel_x, offset_x, size_x);
        ly_next[0] = lane_init(pixel_y, offset_y, size_y);
        for (int k = 0; k < NS; k++)
        begin
            tx = lx_reg[k];
            ty = ly_reg[k];
            for (int j = 0; j < prg_pkg::RATIO_STEPS; j++)
            begin
                tx = lane_step(tx, size_x);
                ty = lane_step(ty, size_y);
            end
            lx_next[k+1] = tx;
            ly_next[k+1] = ty;
        end
        rx_next = lane_final(lx_reg[NS]);
        ry_raw  = lane_final(ly_reg[NS]);
        ry_next = ONE - ry_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NS; k++)
        begin
            lx_reg[k] <= lx_next[k];
            ly_reg[k] <= ly_next[k];
        end
        rx_reg <= rx_next;
        ry_reg <= ry_next;
    end

    assign out_valid = vld_reg[NS+1];
    assign ratio_x   = rx_reg;
    assign ratio_y   = ry_reg;

endmodule

// ===== design/pinhole_ray_generator_unit.sv =====
// Pinhole camera ray generator. One pixel sample is taken per clock whenever
// busy is low (busy is high during reset and for the first cycle after it).
// Each sample returns one ray on the result ports. done marks the ray for one
// cycle. The results cannot be held off. The sample passes through the
// pipelined restoring dividers (ratio and direction scaling) and the
// pipelined square root, each retiring a fixed number of bits per stage.
// Configuration may be written only while no sample is in flight.
module pinhole_ray_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [15:0]                   pixel_x,
    input  logic [15:0]                   pixel_y,
    input  logic [15:0]                   offset_x,
    input  logic [15:0]                   offset_y,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [prg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output logic                          done,
    output logic signed [31:0]            origin_x,
    output logic signed [31:0]            origin_y,
    output logic signed [31:0]            origin_z,
    output logic signed [15:0]            direction_x,
    output logic signed [15:0]            direction_y,
    output logic signed [15:0]            direction_z,
    output logic                          degenerate
);

    localparam int NSQ  = prg_pkg::SQRT_STAGES;
    localparam int NDV  = prg_pkg::DIV_STAGES;
    localparam int DW   = prg_pkg::DW;
    localparam int ST_SQ0   = 10;
    localparam int ST_SQL   = ST_SQ0 + NSQ;
    localparam int ST_DV0   = ST_SQL + 1;
    localparam int PIPE_LEN = ST_DV0 + NDV + 3;
    localparam int EYE_SHIFT = 16 - prg_pkg::VEC_FRAC_BITS;
    localparam logic [31:0] ROOT_MIN = 32'(1) << (prg_pkg::NORM_BITS - 1);
    localparam logic signed [35:0] O_MAX = 36'sh07FFFFFFF;
    localparam logic signed [35:0] O_MIN = 36'shF80000000;

    typedef struct packed {
        logic [2:0][29:0] e;
        logic [2:0]       neg;
        logic             deg;
    } side_t;

    // Configuration registers
    logic [62:0] basis_u_reg;
    logic [62:0] basis_v_reg;
    logic [62:0] basis_w_reg;
    logic [62:0] eye_reg;
    logic [63:0] win_h_reg;
    logic [63:0] win_v_reg;
    logic [31:0] near_reg;
    logic [31:0] raster_reg;
    logic        busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_u_reg <= '0;
            basis_v_reg <= '0;
            basis_w_reg <= '0;
            eye_reg     <= '0;
            win_h_reg   <= '0;
            win_v_reg   <= '0;
            near_reg    <= '0;
            raster_reg  <= prg_pkg::RASTER_RESET;
            busy_reg    <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    prg_pkg::REG_BASIS_U:  basis_u_reg <= cfg_data[62:0];
                    prg_pkg::REG_BASIS_V:  basis_v_reg <= cfg_data[62:0];
                    prg_pkg::REG_BASIS_W:  basis_w_reg <= cfg_data[62:0];
                    prg_pkg::REG_EYE:      eye_reg     <= cfg_data[62:0];
                    prg_pkg::REG_WINDOW_H: win_h_reg   <= cfg_data;
                    prg_pkg::REG_WINDOW_V: win_v_reg   <= cfg_data;
                    prg_pkg::REG_NEAR:     near_reg    <= cfg_data[31:0];
                    prg_pkg::REG_RASTER:   raster_reg  <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    // Unpacked components
    logic signed [20:0] uc [3];
    logic signed [20:0] vc [3];
    logic signed [20:0] wc [3];
    logic signed [20:0] ec [3];
    logic signed [31:0] win_l;
    logic signed [31:0] win_r;
    logic signed [31:0] win_b;
    logic signed [31:0] win_t;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            uc[k] = basis_u_reg[62 - 21*k -: 21];
            vc[k] = basis_v_reg[62 - 21*k -: 21];
            wc[k] = basis_w_reg[62 - 21*k -: 21];
            ec[k] = eye_reg[62 - 21*k -: 21];
        end
    end

    assign win_l = win_h_reg[63:32];
    assign win_r = win_h_reg[31:0];
    assign win_b = win_v_reg[63:32];
    assign win_t = win_v_reg[31:0];

    // Sample ratios
    logic        ratio_valid;
    logic [24:0] ratio_x;
    logic [24:0] ratio_y;

    prg_ratio u_ratio (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy_reg),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .raster_size (raster_reg),
        .out_valid   (ratio_valid),
        .ratio_x     (ratio_x),
        .ratio_y     (ratio_y)
    );

    // Valid bits travel with the stages
    logic [PIPE_LEN:1] pipe_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= '0;
        end
        else
        begin
            pipe_vld_reg <= {pipe_vld_reg[PIPE_LEN-1:1], ratio_valid};
        end
    end

    // Window span products
    logic signed [58:0] prod_x_reg, prod_x_next;
    logic signed [58:0] prod_y_reg, prod_y_next;
    logic signed [32:0] span_x;
    logic signed [32:0] span_y;

    always_comb
    begin
        span_x      = 33'(win_r) - 33'(win_l);
        span_y      = 33'(win_t) - 33'(win_b);
        prod_x_next = $signed({1'b0, ratio_x}) * span_x;
        prod_y_next = $signed({1'b0, ratio_y}) * span_y;
    end

    // Window point
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;

    always_comb
    begin
        logic signed [58:0] sx;
        logic signed [58:0] sy;
        sx     = (prod_x_reg >>> prg_pkg::RATIO_BITS) + 59'(win_l);
        sy     = (prod_y_reg >>> prg_pkg::RATIO_BITS) + 59'(win_b);
        x_next = sx[31:0];
        y_next = sy[31:0];
    end

    // Basis products, direction sum, magnitudes
    logic signed [52:0] pu_reg [3], pu_next [3];
    logic signed [52:0] pv_reg [3], pv_next [3];
    logic signed [54:0] d_reg [3], d_next [3];
    logic [DW-1:0]      a_reg [3], a_next [3];
    logic [2:0]         neg_reg, neg_next;

    always_comb
    begin
        logic signed [54:0] nd;
        for (int k = 0; k < 3; k++)
        begin
            pu_next[k]  = x_reg * uc[k];
            pv_next[k]  = y_reg * vc[k];
            d_next[k]   = 55'(pu_reg[k]) + 55'(pv_reg[k]) + (55'(wc[k]) <<< 16);
            nd          = -d_reg[k];
            neg_next[k] = d_reg[k][54];
            a_next[k]   = d_reg[k][54] ? nd[DW-1:0] : d_reg[k][DW-1:0];
        end
    end

    // Largest magnitude
    logic [DW-1:0] m_reg, m_next;
    logic [DW-1:0] ma_reg [3];
    logic [2:0]    mneg_reg;
    logic          mdeg_reg, mdeg_next;

    always_comb
    begin
        m_next    = (a_reg[0] > a_reg[1]) ? a_reg[0] : a_reg[1];
        m_next    = (a_reg[2] > m_next) ? a_reg[2] : m_next;
        mdeg_next = ((a_reg[0] | a_reg[1] | a_reg[2]) == '0);
    end

    // Normalizing shift in two stages: coarse 32/16/8, fine 4/2/1
    logic [DW-1:0] nam_reg, nam_next;
    logic [DW-1:0] naa_reg [3], naa_next [3];
    logic [2:0]    naneg_reg;
    logic          nadeg_reg;
    logic [DW-1:0] nbm_next;
    logic [DW-1:0] nba_reg [3], nba_next [3];
    logic [2:0]    nbneg_reg;
    logic          nbdeg_reg;

    always_comb
    begin
        int s;
        nam_next = m_reg;
        for (int k = 0; k < 3; k++)
        begin
            naa_next[k] = ma_reg[k];
        end
        for (int j = 0; j < 3; j++)
        begin
            s = 32 >> j;
            if ((nam_next >> (DW - s)) == '0)
            begin
                nam_next = nam_next << s;
                for (int k = 0; k < 3; k++)
                begin
                    naa_next[k] = naa_next[k] << s;
                end
            end
        end
        nbm_next = nam_reg;
        for (int k = 0; k < 3; k++)
        begin
            nba_next[k] = naa_reg[k];
        end
        for (int j = 3; j < 6; j++)
        begin
            s = 32 >> j;
            if ((nbm_next >> (DW - s)) == '0)
            begin
                nbm_next = nbm_next << s;
                for (int k = 0; k < 3; k++)
                begin
                    nba_next[k] = nba_next[k] << s;
                end
            end
        end
    end

    // Squares of the normalized components
    logic [59:0] sq_reg [3], sq_next [3];
    side_t       sqside_reg, sqside_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sqside_next.e[k] = nba_reg[k][DW-1 -: prg_pkg::NORM_BITS];
            sq_next[k]       = sqside_next.e[k] * sqside_next.e[k];
        end
        sqside_next.neg = nbneg_reg;
        sqside_next.deg = nbdeg_reg;
    end

    // Square root, one result bit per step
    logic [34:0] srem_reg [NSQ+1], srem_next [NSQ+1];
    logic [31:0] sroot_reg [NSQ+1], sroot_next [NSQ+1];
    logic [63:0] sv_reg [NSQ+1], sv_next [NSQ+1];
    side_t       sside_reg [NSQ+1], sside_next [NSQ+1];

    always_comb
    begin
        logic [61:0] sum;
        logic [34:0] r_rem;
        logic [31:0] r_root;
        logic [63:0] r_v;
        logic [34:0] trial_r;
        logic [34:0] trial_t;
        sum           = 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
        srem_next[0]  = '0;
        sroot_next[0] = '0;
        sv_next[0]    = {2'b00, sum};
        sside_next[0] = sqside_reg;
        for (int k = 0; k < NSQ; k++)
        begin
            r_rem  = srem_reg[k];
            r_root = sroot_reg[k];
            r_v    = sv_reg[k];
            for (int j = 0; j < prg_pkg::SQRT_STEPS; j++)
            begin
                trial_r = {r_rem[32:0], r_v[63:62]};
                trial_t = {1'b0, r_root, 2'b01};
                if (trial_r >= trial_t)
                begin
                    r_rem  = trial_r - trial_t;
                    r_root = {r_root[30:0], 1'b1};
                end
                else
                begin
                    r_rem  = trial_r;
                    r_root = {r_root[30:0], 1'b0};
                end
                r_v = {r_v[61:0], 2'b00};
            end
            srem_next[k+1]  = r_rem;
            sroot_next[k+1] = r_root;
            sv_next[k+1]    = r_v;
            sside_next[k+1] = sside_reg[k];
        end
    end

    // Rounded scaling: (2*e*2^14 + n) / (2*n), one quotient bit per step
    logic [31:0] drem_reg [NDV+1][3], drem_next [NDV+1][3];
    logic [14:0] dlo_reg [NDV+1][3], dlo_next [NDV+1][3];
    logic [31:0] dn_reg [NDV+1], dn_next [NDV+1];
    side_t       dside_reg [NDV+1], dside_next [NDV+1];

    always_comb
    begin
        logic [46:0] numer;
        logic [32:0] t;
        logic [32:0] dd;
        logic [31:0] r_rem;
        logic [14:0] r_lo;
        dn_next[0]    = sroot_reg[NSQ];
        dside_next[0] = sside_reg[NSQ];
        for (int i = 0; i < 3; i++)
        begin
            numer           = {2'b00, sside_reg[NSQ].e[i], 15'b0} + 47'(sroot_reg[NSQ]);
            drem_next[0][i] = numer[46:15];
            dlo_next[0][i]  = numer[14:0];
        end
        for (int k = 0; k < NDV; k++)
        begin
            dd              = {dn_reg[k], 1'b0};
            dn_next[k+1]    = dn_reg[k];
            dside_next[k+1] = dside_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                r_rem = drem_reg[k][i];
                r_lo  = dlo_reg[k][i];
                for (int j = 0; j < prg_pkg::DIV_STEPS; j++)
                begin
                    t = {r_rem, r_lo[14]};
                    if (t >= dd)
                    begin
                        t     = t - dd;
                        r_rem = t[31:0];
                        r_lo  = {r_lo[13:0], 1'b1};
                    end
                    else
                    begin
                        r_rem = t[31:0];
                        r_lo  = {r_lo[13:0], 1'b0};
                    end
                end
                drem_next[k+1][i] = r_rem;
                dlo_next[k+1][i]  = r_lo;
            end
        end
    end

    // Signed direction, near products, origin
    logic signed [15:0] q_reg [3], q_next [3];
    logic               qdeg_reg;
    logic signed [48:0] pn_reg [3], pn_next [3];
    logic signed [15:0] pq_reg [3];
    logic               pdeg_reg;
    logic signed [31:0] org_reg [3], org_next [3];
    logic signed [15:0] dir_reg [3], dir_next [3];
    logic               deg_reg;

    always_comb
    begin
        logic signed [15:0] mag;
        logic signed [35:0] o;
        for (int k = 0; k < 3; k++)
        begin
            mag        = {1'b0, dlo_reg[NDV][k]};
            q_next[k]  = dside_reg[NDV].neg[k] ? -mag : mag;
            pn_next[k] = q_reg[k] * $signed({1'b0, near_reg});
            o          = (36'(ec[k]) <<< EYE_SHIFT) + 36'(pn_reg[k] >>> prg_pkg::DIR_FRAC);
            if (o > O_MAX)
            begin
                o = O_MAX;
            end
            else if (o < O_MIN)
            begin
                o = O_MIN;
            end
            org_next[k] = pdeg_reg ? 32'sd0 : o[31:0];
            dir_next[k] = pdeg_reg ? 16'sd0 : pq_reg[k];
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        for (int k = 0; k < 3; k++)
        begin
            pu_reg[k]  <= pu_next[k];
            pv_reg[k]  <= pv_next[k];
            d_reg[k]   <= d_next[k];
            a_reg[k]   <= a_next[k];
            ma_reg[k]  <= a_reg[k];
            naa_reg[k] <= naa_next[k];
            nba_reg[k] <= nba_next[k];
            sq_reg[k]  <= sq_next[k];
            q_reg[k]   <= q_next[k];
            pn_reg[k]  <= pn_next[k];
            pq_reg[k]  <= q_reg[k];
            org_reg[k] <= org_next[k];
            dir_reg[k] <= dir_next[k];
        end
        neg_reg    <= neg_next;
        m_reg      <= m_next;
        mneg_reg   <= neg_reg;
        mdeg_reg   <= mdeg_next;
        nam_reg    <= nam_next;
        naneg_reg  <= mneg_reg;
        nadeg_reg  <= mdeg_reg;
        nbneg_reg  <= naneg_reg;
        nbdeg_reg  <= nadeg_reg;
        sqside_reg <= sqside_next;
        for (int k = 0; k <= NSQ; k++)
        begin
            srem_reg[k]  <= srem_next[k];
            sroot_reg[k] <= sroot_next[k];
            sv_reg[k]    <= sv_next[k];
            sside_reg[k] <= sside_next[k];
        end
        for (int k = 0; k <= NDV; k++)
        begin
            dn_reg[k]    <= dn_next[k];
            dside_reg[k] <= dside_next[k];
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[k][i] <= drem_next[k][i];
                dlo_reg[k][i]  <= dlo_next[k][i];
            end
        end
        qdeg_reg <= dside_reg[NDV].deg;
        pdeg_reg <= qdeg_reg;
        deg_reg  <= pdeg_reg;
    end

    // Result ports
    assign done        = pipe_vld_reg[PIPE_LEN];
    assign origin_x    = org_reg[0];
    assign origin_y    = org_reg[1];
    assign origin_z    = org_reg[2];
    assign direction_x = dir_reg[0];
    assign direction_y = dir_reg[1];
    assign direction_z = dir_reg[2];
    assign degenerate  = deg_reg;

    // A zero-length direction gives an all-zero ray
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> direction_x == 16'sd0 && direction_y == 16'sd0 &&
            direction_z == 16'sd0 && origin_x == 32'sd0 && origin_y == 32'sd0 &&
            origin_z == 32'sd0)
        else $error("degenerate ray with nonzero fields");

    // Unit components never exceed one
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> direction_x <= 16'sd16384 && direction_x >= -16'sd16384 &&
            direction_y <= 16'sd16384 && direction_y >= -16'sd16384 &&
            direction_z <= 16'sd16384 && direction_z >= -16'sd16384)
        else $error("direction component out of range");

    // A proper ray has a nonzero direction
    a_dir_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> direction_x != 16'sd0 || direction_y != 16'sd0 ||
            direction_z != 16'sd0)
        else $error("nondegenerate ray with zero direction");

    // Normalized length keeps the root at or above half scale
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg[ST_SQL] && !sside_reg[NSQ].deg |-> sroot_reg[NSQ] >= ROOT_MIN)
        else $error("square root below normalized floor");

endmodule
